// ----- rtl/fqks_pkg.sv -----
package fqks_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 4;
  localparam int OCC_W   = 4;
  localparam int KEY_W   = 56;
  localparam int MH_W    = 16;
  localparam int ML_W    = 64;
  localparam int YEAR_W  = 16;
  localparam int REC_W   = KEY_W + MH_W + ML_W + YEAR_W;
  localparam int IN_DATA_W  = ((REC_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((REC_W + OCC_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - REC_W - OCC_W;
  localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [ML_W-1:0]   model_low;
    logic [MH_W-1:0]   model_high;
    logic [KEY_W-1:0]  plate;
  } rec_t;

  typedef struct packed {
    logic            load;
    logic            exec_commit;
    logic            rd_start;
    logic            scan_next;
    logic            set_res;
    logic [ST_W-1:0] res_code;
    logic            done_commit;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            out_free;
    logic            match;
    logic            last;
  } sts_t;

endpackage

// ----- rtl/fqks_ctrl.sv -----
module fqks_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fqks_pkg::sts_t sts,
  output fqks_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_code = fqks_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.op == fqks_pkg::OP_DEQ && !sts.empty) begin
          cmd.rd_start = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_code = fqks_pkg::ST_OK;
          state_next = S_DONE;
        end else if (sts.op == fqks_pkg::OP_SEARCH && !sts.empty) begin
          cmd.rd_start = 1'b1;
          state_next = S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec_commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.set_res = 1'b1;
          cmd.res_code = fqks_pkg::ST_OK;
          state_next = S_DONE;
        end else if (sts.last) begin
          cmd.set_res = 1'b1;
          cmd.res_code = fqks_pkg::ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done_commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC)
    else $error("accepted transaction did not enter execution");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec_commit || cmd.done_commit) |-> sts.out_free)
    else $error("result written while output register is occupied");

  a_scan_step: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_next |-> (!sts.match && !sts.last))
    else $error("scan advanced past a match or the last entry");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !sts.empty)
    else $error("scan running on an empty queue");

endmodule

// ----- rtl/fqks_dp.sv -----
module fqks_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [fqks_pkg::CFG_W-1:0]      cfg_data,
  input  logic [fqks_pkg::IN_DATA_W-1:0]  in_data,
  input  logic [fqks_pkg::OP_W-1:0]       in_op,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fqks_pkg::OUT_DATA_W-1:0] out_data,
  output logic [fqks_pkg::ST_W-1:0]       out_status,
  input  fqks_pkg::cmd_t                  cmd,
  output fqks_pkg::sts_t                  sts
);

  fqks_pkg::rec_t rec_mem [fqks_pkg::DEPTH];
  fqks_pkg::rec_t rd_data;
  fqks_pkg::rec_t in_rec;
  fqks_pkg::rec_t out_rec;

  logic [fqks_pkg::OP_W-1:0]  op;
  logic [fqks_pkg::CNT_W-1:0] cap;
  logic [fqks_pkg::IDX_W-1:0] head;
  logic [fqks_pkg::IDX_W-1:0] tail;
  logic [fqks_pkg::CNT_W-1:0] count;
  logic [fqks_pkg::IDX_W-1:0] pos;
  logic [fqks_pkg::ST_W-1:0]  res_code;
  logic [fqks_pkg::OCC_W-1:0] out_occ;

  logic [fqks_pkg::CNT_W:0]   rd_sum;
  logic [fqks_pkg::CNT_W:0]   rd_wrap;
  logic [fqks_pkg::CNT_W-1:0] rd_off;
  logic [fqks_pkg::IDX_W-1:0] rd_addr;
  logic                       rd_en;
  logic [fqks_pkg::CNT_W-1:0] tail_p1;
  logic [fqks_pkg::IDX_W-1:0] tail_inc;
  logic [fqks_pkg::CNT_W-1:0] head_p1;
  logic [fqks_pkg::IDX_W-1:0] head_inc;
  logic [fqks_pkg::CNT_W-1:0] pos_p1;
  logic [fqks_pkg::CMP_W-1:0] cfg_ext;
  logic [fqks_pkg::CMP_W-1:0] cap_sel;
  logic [fqks_pkg::CNT_W-1:0] cap_new;
  logic                       full;
  logic                       empty;
  logic                       wr_en;
  logic [fqks_pkg::ST_W-1:0]  exec_code;

  assign full  = (count >= cap);
  assign empty = (count == '0);

  assign pos_p1 = fqks_pkg::CNT_W'(pos) + fqks_pkg::CNT_W'(1);
  assign rd_off = cmd.rd_start ? '0 : pos_p1;
  assign rd_sum = (fqks_pkg::CNT_W+1)'(head) + (fqks_pkg::CNT_W+1)'(rd_off);
  assign rd_wrap = (rd_sum >= (fqks_pkg::CNT_W+1)'(cap))
                 ? rd_sum - (fqks_pkg::CNT_W+1)'(cap) : rd_sum;
  assign rd_addr = rd_wrap[fqks_pkg::IDX_W-1:0];
  assign rd_en = cmd.rd_start | cmd.scan_next;

  assign tail_p1  = fqks_pkg::CNT_W'(tail) + fqks_pkg::CNT_W'(1);
  assign tail_inc = (tail_p1 == cap) ? '0 : tail_p1[fqks_pkg::IDX_W-1:0];
  assign head_p1  = fqks_pkg::CNT_W'(head) + fqks_pkg::CNT_W'(1);
  assign head_inc = (head_p1 == cap) ? '0 : head_p1[fqks_pkg::IDX_W-1:0];

  assign cfg_ext = fqks_pkg::CMP_W'(cfg_data);
  assign cap_sel = (cfg_ext == '0) ? fqks_pkg::CMP_W'(1)
                 : (cfg_ext > fqks_pkg::CMP_W'(fqks_pkg::DEPTH))
                 ? fqks_pkg::CMP_W'(fqks_pkg::DEPTH) : cfg_ext;
  assign cap_new = cap_sel[fqks_pkg::CNT_W-1:0];

  assign wr_en = cmd.exec_commit && (op == fqks_pkg::OP_ENQ) && !full;

  always_comb begin
    case (op)
      fqks_pkg::OP_ENQ:    exec_code = full ? fqks_pkg::ST_FULL : fqks_pkg::ST_OK;
      fqks_pkg::OP_DEQ:    exec_code = fqks_pkg::ST_EMPTY;
      fqks_pkg::OP_SEARCH: exec_code = fqks_pkg::ST_EMPTY;
      default:             exec_code = fqks_pkg::ST_OK;
    endcase
  end

  assign sts.op       = op;
  assign sts.empty    = empty;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.match    = (rd_data.plate == in_rec.plate);
  assign sts.last     = (pos_p1 >= count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[tail_inc] <= in_rec;
    end
    if (rd_en) begin
      rd_data <= rec_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_rec <= fqks_pkg::rec_t'(in_data[fqks_pkg::REC_W-1:0]);
      op <= in_op;
    end
    if (cmd.rd_start) begin
      pos <= '0;
    end else if (cmd.scan_next) begin
      pos <= pos_p1[fqks_pkg::IDX_W-1:0];
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
    end
    if (cmd.exec_commit) begin
      out_status <= exec_code;
      out_rec <= '0;
      out_occ <= fqks_pkg::OCC_W'(wr_en ? count + fqks_pkg::CNT_W'(1) : count);
    end else if (cmd.done_commit) begin
      out_status <= res_code;
      out_rec <= (res_code == fqks_pkg::ST_OK) ? rd_data : '0;
      out_occ <= fqks_pkg::OCC_W'((op == fqks_pkg::OP_DEQ)
                                  ? count - fqks_pkg::CNT_W'(1) : count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= fqks_pkg::CNT_W'(fqks_pkg::DEPTH);
      head <= '0;
      tail <= fqks_pkg::IDX_W'(fqks_pkg::DEPTH - 1);
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap <= cap_new;
        head <= '0;
        tail <= fqks_pkg::IDX_W'(cap_new - fqks_pkg::CNT_W'(1));
        count <= '0;
      end else if (wr_en) begin
        tail <= tail_inc;
        count <= count + fqks_pkg::CNT_W'(1);
      end else if (cmd.done_commit && op == fqks_pkg::OP_DEQ) begin
        head <= head_inc;
        count <= count - fqks_pkg::CNT_W'(1);
      end
      if (cmd.exec_commit || cmd.done_commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {{fqks_pkg::OUT_PAD_W{1'b0}}, out_occ, out_rec};

endmodule

// ----- rtl/fifo_queue_with_key_search_top.sv -----
// One transaction at a time; the next is accepted at the earliest edge its result can be taken.
// Enqueue, unused codes and empty or full reports: the result is registered from the execute state.
// Dequeue: adds one registered record memory read before the result is registered.
// Search over n queued records: up to n key compares, one key compare per cycle.
// A result held by the receiver stalls the next result and, through it, the input.
// Reset empties the queue (head 0, tail 7, count 0) and sets capacity to 8; storage is kept.
module fifo_queue_with_key_search_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fqks_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // plate, model_high, model_low, year
  input  logic [fqks_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [fqks_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_plate, out_model_high, out_model_low, out_year, occupancy, zero pad
  output logic [fqks_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [fqks_pkg::ST_W-1:0]       m_axis_tuser
);

  fqks_pkg::cmd_t cmd;
  fqks_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fqks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqks_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_data    (s_axis_tdata),
    .in_op      (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_status (m_axis_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
